// File: rtl/tre_pkg.sv
// Shared constants, types and helpers for the triangle edge rasterizer.
// Used by tre_setup and triangle_edge_raster_top; no dependencies.
package tre_pkg;

	localparam int COORD_BITS  = 14;
	localparam int SCREEN_BITS = 12;
	localparam int CHANNELS    = 3;
	localparam int DIM_W       = 13;
	localparam int COLOR_W     = 8;
	localparam int ADDR_W      = 26;
	localparam int NUM_VERT    = 3;
	localparam int CFG_IDX_W   = 1;

	// signed width holding any vertex, pixel or difference of the two
	localparam int DIFF_W     = ((COORD_BITS > SCREEN_BITS + 1) ? COORD_BITS : SCREEN_BITS + 1) + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int EFF_W      = SCREEN_BITS + 1;
	localparam int EXT_W      = (DIM_W > EFF_W) ? DIM_W : EFF_W;
	localparam int SCREEN_MAX = 1 << SCREEN_BITS;
	localparam int ROW_W      = SCREEN_BITS + EFF_W;
	localparam int ADDR_SUM_W = ROW_W + 1;
	localparam int ADDR_MUL_W = ADDR_SUM_W + 3;

	localparam int IN_TDATA_W  = ((2 * NUM_VERT * COORD_BITS + 3 * COLOR_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((2 * SCREEN_BITS + ADDR_W + 3 * COLOR_W + 7) / 8) * 8;
	localparam int COLOR_LSB   = 2 * NUM_VERT * COORD_BITS;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [SCREEN_BITS-1:0]       scr_t;
	typedef logic [DIM_W-1:0]             dim_t;
	typedef logic [COLOR_W-1:0]           color_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [PROD_W-1:0]     prod_t;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_STEP = 1'b1
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} cfg_reg_t;

	// clipped bounding box handed from setup to the scan control
	typedef struct packed {
		scr_t lo_x;
		scr_t lo_y;
		scr_t hi_x;
		scr_t hi_y;
		logic empty;
	} box_t;

	// register value clamped to the largest supported screen size
	function automatic logic [EFF_W-1:0] eff_dim(input dim_t r);
		logic [EXT_W-1:0] ext;
		begin
			ext = EXT_W'(r);
			if (ext > EXT_W'(SCREEN_MAX)) ext = EXT_W'(SCREEN_MAX);
			return EFF_W'(ext);
		end
	endfunction

	function automatic diff_t ext_coord(input coord_t v);
		return {{(DIFF_W-COORD_BITS){v[COORD_BITS-1]}}, v};
	endfunction

	function automatic diff_t ext_pix(input scr_t p);
		return DIFF_W'(p);
	endfunction

endpackage

// File: rtl/tre_setup.sv
// Triangle setup: vertex bounding box clipped to the screen, and the
// zero-area test. Combinational; depends on tre_pkg.
module tre_setup (
	input  tre_pkg::coord_t [tre_pkg::NUM_VERT-1:0] vx,
	input  tre_pkg::coord_t [tre_pkg::NUM_VERT-1:0] vy,
	input  tre_pkg::dim_t                           width,
	input  tre_pkg::dim_t                           height,
	output tre_pkg::box_t                           box
);
	import tre_pkg::*;

	diff_t min_x, max_x, min_y, max_y;
	diff_t lim_x, lim_y;
	diff_t lo_x, lo_y, hi_x, hi_y;
	diff_t dx1, dy1, dx2, dy2;
	prod_t area_a, area_b;

	always_comb begin
		min_x = ext_coord(vx[0]);
		max_x = ext_coord(vx[0]);
		min_y = ext_coord(vy[0]);
		max_y = ext_coord(vy[0]);
		for (int i = 1; i < NUM_VERT; i++) begin
			if (ext_coord(vx[i]) < min_x) min_x = ext_coord(vx[i]);
			if (ext_coord(vx[i]) > max_x) max_x = ext_coord(vx[i]);
			if (ext_coord(vy[i]) < min_y) min_y = ext_coord(vy[i]);
			if (ext_coord(vy[i]) > max_y) max_y = ext_coord(vy[i]);
		end
	end

	// last usable column/row; -1 when the register is zero
	assign lim_x = DIFF_W'(eff_dim(width)) - DIFF_W'(1);
	assign lim_y = DIFF_W'(eff_dim(height)) - DIFF_W'(1);

	assign lo_x = min_x[DIFF_W-1] ? '0 : min_x;
	assign lo_y = min_y[DIFF_W-1] ? '0 : min_y;
	assign hi_x = (max_x > lim_x) ? lim_x : max_x;
	assign hi_y = (max_y > lim_y) ? lim_y : max_y;

	// doubled signed area is zero when both cross terms match
	assign dx1 = ext_coord(vx[1]) - ext_coord(vx[0]);
	assign dy1 = ext_coord(vy[1]) - ext_coord(vy[0]);
	assign dx2 = ext_coord(vx[2]) - ext_coord(vx[0]);
	assign dy2 = ext_coord(vy[2]) - ext_coord(vy[0]);
	assign area_a = dx1 * dy2;
	assign area_b = dy1 * dx2;

	assign box.lo_x  = SCREEN_BITS'(lo_x);
	assign box.lo_y  = SCREEN_BITS'(lo_y);
	assign box.hi_x  = SCREEN_BITS'(hi_x);
	assign box.hi_y  = SCREEN_BITS'(hi_y);
	assign box.empty = (area_a == area_b) || (lo_x > hi_x) || (lo_y > hi_y);

endmodule

// File: rtl/triangle_edge_raster_top.sv
// Edge-function triangle rasterizer, top level.
// Depends on tre_pkg and tre_setup.

// A load word latches three vertices and a fill color; it returns nothing
// when the clipped box holds pixels, or a single notice word (all zero
// coordinates, fill color, tlast high) when the area is zero or the box is
// empty. Each step word then returns one pixel of the box in row-major
// order with its byte address and a covered flag (tuser); tlast marks the
// final pixel. One word is taken per clock, steps included, unless m_tready
// back-pressure stalls the pipe; a result passes through the input register,
// edge difference stage, multiplier stage (all edge products and the row
// address product), then the output register. Steps while idle are dropped.
module triangle_edge_raster_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
	// fill_red, fill_green, fill_blue, zero pad
	input  logic [tre_pkg::IN_TDATA_W-1:0]       s_tdata,
	// action
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// pixel_x, pixel_y, byte_address, out_red, out_green, out_blue, zero pad
	output logic [tre_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// covered
	output logic                                 m_tuser,
	// last_pixel
	output logic                                 m_tlast,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tre_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tre_pkg::DIM_W-1:0]            cfg_data
);
	import tre_pkg::*;

	// configuration
	dim_t width_q, height_q;

	// stage 1: input register
	logic                  v_s1;
	logic                  act_s1;
	logic [IN_TDATA_W-1:0] data_s1;

	// stage 2: edge differences
	logic   v_s2, r_s2, notice_s2, last_s2;
	scr_t   px_s2, py_s2;
	color_t red_s2, green_s2, blue_s2;
	diff_t  ea_s2 [NUM_VERT];
	diff_t  eb_s2 [NUM_VERT];
	diff_t  ec_s2 [NUM_VERT];
	diff_t  ed_s2 [NUM_VERT];

	// stage 3: products
	logic             v_s3, notice_s3, last_s3;
	scr_t             px_s3, py_s3;
	color_t           red_s3, green_s3, blue_s3;
	prod_t            pab_s3 [NUM_VERT];
	prod_t            pcd_s3 [NUM_VERT];
	logic [ROW_W-1:0] row_s3;

	// output register
	logic              out_valid_q, covered_q, last_q;
	scr_t              px_q, py_q;
	logic [ADDR_W-1:0] addr_q;
	color_t            red_q, green_q, blue_q;

	// scan state and stored triangle
	logic   busy_q;
	scr_t   scan_x_q, scan_y_q, box_min_x_q, box_max_x_q, box_max_y_q;
	coord_t vx_q [NUM_VERT];
	coord_t vy_q [NUM_VERT];
	color_t red_st_q, green_st_q, blue_st_q;

	// handshake chain
	logic adv_s1, rdy_s2, adv_s2, rdy_s3, adv_s3, rdy_out;

	coord_t [NUM_VERT-1:0] vx_in, vy_in;
	color_t                red_in, green_in, blue_in;
	box_t                  box;
	logic                  is_load, step_last, r_s1;
	diff_t                 ea_d [NUM_VERT];
	diff_t                 eb_d [NUM_VERT];
	diff_t                 ec_d [NUM_VERT];
	diff_t                 ed_d [NUM_VERT];
	logic [NUM_VERT-1:0]   edge_ok;
	logic [ADDR_SUM_W-1:0] addr_sum;
	logic [EFF_W-1:0]      eff_w;

	assign rdy_out  = !out_valid_q || m_tready;
	assign adv_s3   = v_s3 && rdy_out;
	assign rdy_s3   = !v_s3 || adv_s3;
	assign adv_s2   = v_s2 && (!r_s2 || rdy_s3);
	assign rdy_s2   = !v_s2 || adv_s2;
	assign adv_s1   = v_s1 && rdy_s2;
	assign s_tready = !v_s1 || adv_s1;
	assign cfg_ready = 1'b1;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1024);
			height_q <= DIM_W'(1024);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_SCREEN_WIDTH:  width_q <= cfg_data;
				REG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_s1  <= s_tuser;
			data_s1 <= s_tdata;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_VERT; i++) begin
			vx_in[i] = data_s1[(2*i)*COORD_BITS +: COORD_BITS];
			vy_in[i] = data_s1[(2*i+1)*COORD_BITS +: COORD_BITS];
		end
	end
	assign red_in   = data_s1[COLOR_LSB +: COLOR_W];
	assign green_in = data_s1[COLOR_LSB + COLOR_W +: COLOR_W];
	assign blue_in  = data_s1[COLOR_LSB + 2*COLOR_W +: COLOR_W];

	tre_setup u_setup (
		.vx     (vx_in),
		.vy     (vy_in),
		.width  (width_q),
		.height (height_q),
		.box    (box)
	);

	assign is_load   = (action_t'(act_s1) == ACT_LOAD);
	assign step_last = (scan_x_q == box_max_x_q) && (scan_y_q == box_max_y_q);
	assign r_s1      = is_load ? box.empty : busy_q;

	// edge k runs from vertex k+1 to vertex k+2
	for (genvar k = 0; k < NUM_VERT; k++) begin : g_edge
		localparam int IA = (k + 1) % NUM_VERT;
		localparam int IB = (k + 2) % NUM_VERT;
		assign ea_d[k] = ext_coord(vx_q[IB]) - ext_coord(vx_q[IA]);
		assign eb_d[k] = ext_pix(scan_y_q) - ext_coord(vy_q[IA]);
		assign ec_d[k] = ext_coord(vy_q[IB]) - ext_coord(vy_q[IA]);
		assign ed_d[k] = ext_pix(scan_x_q) - ext_coord(vx_q[IA]);
		assign edge_ok[k] = (pab_s3[k] >= pcd_s3[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			scan_x_q    <= '0;
			scan_y_q    <= '0;
			box_min_x_q <= '0;
			box_max_x_q <= '0;
			box_max_y_q <= '0;
		end else if (adv_s1) begin
			if (is_load) begin
				busy_q <= !box.empty;
				if (!box.empty) begin
					box_min_x_q <= box.lo_x;
					box_max_x_q <= box.hi_x;
					box_max_y_q <= box.hi_y;
					scan_x_q    <= box.lo_x;
					scan_y_q    <= box.lo_y;
				end
			end else if (busy_q) begin
				if (step_last) begin
					busy_q <= 1'b0;
				end else if (scan_x_q >= box_max_x_q) begin
					scan_x_q <= box_min_x_q;
					scan_y_q <= scan_y_q + SCREEN_BITS'(1);
				end else begin
					scan_x_q <= scan_x_q + SCREEN_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_load) begin
			for (int i = 0; i < NUM_VERT; i++) begin
				vx_q[i] <= vx_in[i];
				vy_q[i] <= vy_in[i];
			end
			red_st_q   <= red_in;
			green_st_q <= green_in;
			blue_st_q  <= blue_in;
		end
	end

	// ---------------- stage 2 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			r_s2      <= r_s1;
			notice_s2 <= is_load;
			last_s2   <= is_load ? 1'b1 : step_last;
			px_s2     <= is_load ? '0 : scan_x_q;
			py_s2     <= is_load ? '0 : scan_y_q;
			red_s2    <= is_load ? red_in : red_st_q;
			green_s2  <= is_load ? green_in : green_st_q;
			blue_s2   <= is_load ? blue_in : blue_st_q;
			for (int k = 0; k < NUM_VERT; k++) begin
				ea_s2[k] <= ea_d[k];
				eb_s2[k] <= eb_d[k];
				ec_s2[k] <= ec_d[k];
				ed_s2[k] <= ed_d[k];
			end
		end
	end

	// ---------------- stage 3 ----------------
	assign eff_w = eff_dim(width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2 && r_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && r_s2) begin
			notice_s3 <= notice_s2;
			last_s3   <= last_s2;
			px_s3     <= px_s2;
			py_s3     <= py_s2;
			red_s3    <= red_s2;
			green_s3  <= green_s2;
			blue_s3   <= blue_s2;
			row_s3    <= ROW_W'(py_s2) * ROW_W'(eff_w);
			for (int k = 0; k < NUM_VERT; k++) begin
				pab_s3[k] <= ea_s2[k] * eb_s2[k];
				pcd_s3[k] <= ec_s2[k] * ed_s2[k];
			end
		end
	end

	// ---------------- output register ----------------
	assign addr_sum = ADDR_SUM_W'(row_s3) + ADDR_SUM_W'(px_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			px_q      <= px_s3;
			py_q      <= py_s3;
			addr_q    <= ADDR_W'(ADDR_MUL_W'(addr_sum) * ADDR_MUL_W'(CHANNELS));
			covered_q <= !notice_s3 && (&edge_ok);
			red_q     <= red_s3;
			green_q   <= green_s3;
			blue_q    <= blue_s3;
			last_q    <= last_s3;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = covered_q;
	assign m_tlast  = last_q;
	assign m_tdata  = OUT_TDATA_W'({blue_q, green_q, red_q, addr_q, py_q, px_q});

`ifndef ASSERT_OFF
	a_scan_x_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (scan_x_q >= box_min_x_q) && (scan_x_q <= box_max_x_q))
		else $error("scan column left the bounding box");

	a_scan_y_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (scan_y_q <= box_max_y_q))
		else $error("scan row passed the bounding box");

	a_last_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !is_load && busy_q && step_last) |=> !busy_q)
		else $error("scan still busy after its last pixel");

	a_load_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && is_load && !box.empty) |=>
		(busy_q && (scan_x_q == $past(box.lo_x)) && (scan_y_q == $past(box.lo_y))))
		else $error("load did not start the scan at the box corner");
`endif

endmodule

// File: tb/sv/tb_triangle_edge_raster_top.sv
// Self-checking testbench for triangle_edge_raster_top: stream stimulus, screen setup
// writes, and a scoreboard that predicts every pixel word. Depends on tre_pkg and the RTL.
module tb_triangle_edge_raster_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tre_pkg::*;

	localparam int PY_LSB    = SCREEN_BITS;
	localparam int ADDR_LSB  = 2 * SCREEN_BITS;
	localparam int RED_LSB   = ADDR_LSB + ADDR_W;
	localparam int GREEN_LSB = RED_LSB + COLOR_W;
	localparam int BLUE_LSB  = GREEN_LSB + COLOR_W;
	localparam int PIPE_PAD  = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS = 140;
	localparam int NUM_PHASES  = 12;

	typedef struct packed {
		action_t         action;
		coord_t [2:0]    vx;
		coord_t [2:0]    vy;
		color_t          red;
		color_t          green;
		color_t          blue;
	} tri_word_t;

	typedef struct packed {
		scr_t              px;
		scr_t              py;
		logic [ADDR_W-1:0] addr;
		logic              covered;
		color_t            red;
		color_t            green;
		color_t            blue;
		logic              last;
	} pixel_t;

	class raster_scoreboard;
		dim_t    width_reg = 13'd1024;
		dim_t    height_reg = 13'd1024;
		bit      scanning;
		int      scan_x, scan_y, min_x, max_x, max_y;
		longint  vx[3];
		longint  vy[3];
		color_t  red, green, blue;
		pixel_t  pixel_q[$];
		int      errors;

		function void write_reg(cfg_reg_t idx, dim_t val);
			if (idx == REG_SCREEN_WIDTH) width_reg = val;
			else if (idx == REG_SCREEN_HEIGHT) height_reg = val;
		endfunction

		function int clamp_dim(dim_t r);
			return (r > SCREEN_MAX) ? SCREEN_MAX : int'(r);
		endfunction

		function longint orient2d(longint ax, longint ay, longint bx, longint by,
		                          longint cx, longint cy);
			return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
		endfunction

		function int pending();
			return pixel_q.size();
		endfunction

		// steps still needed to finish the current box
		function int steps_left();
			if (!scanning) return 0;
			return (max_y - scan_y) * (max_x - min_x + 1) + (max_x - scan_x) + 1;
		endfunction

		function void note_input(tri_word_t w);
			pixel_t p;
			longint lo_x, hi_x, lo_y, hi_y;
			int ew, eh, i;
			p = '0;
			if (w.action == ACT_LOAD) begin
				for (i = 0; i < 3; i++) begin
					vx[i] = longint'(signed'(w.vx[i]));
					vy[i] = longint'(signed'(w.vy[i]));
				end
				red = w.red;
				green = w.green;
				blue = w.blue;
				scanning = 0;
				lo_x = vx[0]; hi_x = vx[0]; lo_y = vy[0]; hi_y = vy[0];
				for (i = 1; i < 3; i++) begin
					if (vx[i] < lo_x) lo_x = vx[i];
					if (vx[i] > hi_x) hi_x = vx[i];
					if (vy[i] < lo_y) lo_y = vy[i];
					if (vy[i] > hi_y) hi_y = vy[i];
				end
				ew = clamp_dim(width_reg);
				eh = clamp_dim(height_reg);
				if (lo_x < 0) lo_x = 0;
				if (lo_y < 0) lo_y = 0;
				if (hi_x > ew - 1) hi_x = ew - 1;
				if (hi_y > eh - 1) hi_y = eh - 1;
				if (orient2d(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]) == 0 ||
				    lo_x > hi_x || lo_y > hi_y) begin
					// empty triangle: one notice word
					p.red = red;
					p.green = green;
					p.blue = blue;
					p.last = 1'b1;
					pixel_q.push_back(p);
				end else begin
					min_x = int'(lo_x);
					max_x = int'(hi_x);
					max_y = int'(hi_y);
					scan_x = int'(lo_x);
					scan_y = int'(lo_y);
					scanning = 1;
				end
			end else if (scanning) begin
				ew = clamp_dim(width_reg);
				p.px = scr_t'(scan_x);
				p.py = scr_t'(scan_y);
				p.addr = ADDR_W'((longint'(scan_y) * ew + scan_x) * CHANNELS);
				p.covered = orient2d(vx[1], vy[1], vx[2], vy[2], scan_x, scan_y) >= 0 &&
				            orient2d(vx[2], vy[2], vx[0], vy[0], scan_x, scan_y) >= 0 &&
				            orient2d(vx[0], vy[0], vx[1], vy[1], scan_x, scan_y) >= 0;
				p.red = red;
				p.green = green;
				p.blue = blue;
				p.last = (scan_x == max_x) && (scan_y == max_y);
				pixel_q.push_back(p);
				if (p.last) begin
					scanning = 0;
				end else if (scan_x >= max_x) begin
					scan_x = min_x;
					scan_y++;
				end else begin
					scan_x++;
				end
			end
		endfunction

		function void show(string what, pixel_t e, pixel_t g);
			errors++;
			if (errors <= 10)
				$display({"%0t mismatch%s: expected x=%0d y=%0d addr=%0d cov=%0b",
				          " rgb=%06h last=%0b, got x=%0d y=%0d addr=%0d cov=%0b",
				          " rgb=%06h last=%0b"},
					$realtime, what, e.px, e.py, e.addr, e.covered,
					{e.red, e.green, e.blue}, e.last, g.px, g.py, g.addr,
					g.covered, {g.red, g.green, g.blue}, g.last);
		endfunction

		function void check_result(pixel_t got);
			pixel_t e;
			string bad;
			bad = "";
			if (pixel_q.size() == 0) begin
				show(" (no word expected)", '0, got);
				return;
			end
			e = pixel_q.pop_front();
			if (got.px != e.px) bad = {bad, " pixel_x"};
			if (got.py != e.py) bad = {bad, " pixel_y"};
			if (got.addr != e.addr) bad = {bad, " byte_address"};
			if (got.covered != e.covered) bad = {bad, " covered"};
			if (got.red != e.red) bad = {bad, " red"};
			if (got.green != e.green) bad = {bad, " green"};
			if (got.blue != e.blue) bad = {bad, " blue"};
			if (got.last != e.last) bad = {bad, " last"};
			if (bad != "") show(bad, e, got);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [DIM_W-1:0]       cfg_data;

	raster_scoreboard sb = new();
	bit tx_gaps;
	bit rx_gaps;
	int hold_len;
	int stall_cycles = 0;

	triangle_edge_raster_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic tri_word_t make_load(int x0, int y0, int x1, int y1, int x2, int y2,
	                                        logic [23:0] rgb);
		tri_word_t w;
		w.action = ACT_LOAD;
		w.vx[0] = coord_t'(x0); w.vy[0] = coord_t'(y0);
		w.vx[1] = coord_t'(x1); w.vy[1] = coord_t'(y1);
		w.vx[2] = coord_t'(x2); w.vy[2] = coord_t'(y2);
		{w.red, w.green, w.blue} = rgb;
		return w;
	endfunction

	function automatic tri_word_t random_word(action_t a);
		tri_word_t w;
		int i;
		w.action = a;
		for (i = 0; i < 3; i++) begin
			w.vx[i] = coord_t'($urandom);
			w.vy[i] = coord_t'($urandom);
		end
		w.red = color_t'($urandom);
		w.green = color_t'($urandom);
		w.blue = color_t'($urandom);
		return w;
	endfunction

	// small triangle anchored anywhere on screen, sometimes hugging an edge or off it
	function automatic tri_word_t small_load(int ew, int eh);
		tri_word_t w;
		int ax, ay, i;
		w = random_word(ACT_LOAD);
		ax = ($urandom_range(0, 3) == 0) ? ew - int'($urandom_range(0, 4))
		                                 : int'($urandom_range(0, ew + 5)) - 4;
		ay = ($urandom_range(0, 3) == 0) ? eh - int'($urandom_range(0, 4))
		                                 : int'($urandom_range(0, eh + 5)) - 4;
		for (i = 0; i < 3; i++) begin
			w.vx[i] = coord_t'(ax + int'($urandom_range(0, 5)));
			w.vy[i] = coord_t'(ay + int'($urandom_range(0, 5)));
		end
		return w;
	endfunction

	task automatic send_word(tri_word_t w);
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= w.action;
		s_tdata <= IN_TDATA_W'({w.blue, w.green, w.red, w.vy[2], w.vx[2], w.vy[1], w.vx[1],
		                        w.vy[0], w.vx[0]});
		do @(posedge clk); while (!s_tready);
		sb.note_input(w);
		@(negedge clk);
	endtask

	task automatic send_steps(int n);
		repeat (n) send_word(random_word(ACT_STEP));
	endtask

	// write both screen registers back to back
	task automatic set_screen(dim_t wv, dim_t hv);
		cfg_valid <= 1'b1;
		cfg_index <= REG_SCREEN_WIDTH;
		cfg_data <= wv;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(REG_SCREEN_WIDTH, wv);
		@(negedge clk);
		cfg_index <= REG_SCREEN_HEIGHT;
		cfg_data <= hv;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(REG_SCREEN_HEIGHT, hv);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop sending, wait for every pixel word, then let any resultless load clear the pipe
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (PIPE_PAD) @(posedge clk);
		@(negedge clk);
	endtask

	// output sink: random stalls, plus one long hold-off on request
	initial begin : sink
		bit held;
		held = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_len != 0 && !held) begin
				m_tready <= 1'b0;
				repeat (hold_len) @(negedge clk);
				held = 1'b1;
			end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result({m_tdata[SCREEN_BITS-1:0], m_tdata[PY_LSB +: SCREEN_BITS],
			                 m_tdata[ADDR_LSB +: ADDR_W], m_tuser,
			                 m_tdata[RED_LSB +: COLOR_W], m_tdata[GREEN_LSB +: COLOR_W],
			                 m_tdata[BLUE_LSB +: COLOR_W], m_tlast});
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_triangle_edge_raster_top failed");
			$finish;
		end
	end

	initial begin : stimulus
		dim_t wv, hv;
		int phase, count, n, k;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_len = 0;
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: reset screen size 1024 x 1024
		send_steps(1);                                      // step while idle
		send_word(make_load(0, 0, 1, 0, 0, 1, 24'hff0000)); // counter-clockwise
		send_steps(4);
		send_word(make_load(0, 0, 0, 1, 1, 0, 24'h00ff00)); // clockwise
		send_steps(4);
		send_word(make_load(2, 2, 5, 5, 9, 9, 24'h0000ff)); // zero area
		send_word(make_load(-9, -9, -2, -9, -9, -1, 24'hffffff)); // box above/left
		send_word(make_load(-8192, -8192, 8191, -8192, -8192, 8191, 24'h000000));
		send_steps(1);
		send_word(make_load(2000, 5, 2005, 5, 2000, 9, 24'h123456)); // abandons, off right
		drain();
		// oversized width, zero height
		set_screen(13'd8191, 13'd0);
		send_word(make_load(0, 0, 3, 0, 0, 3, 24'ha5a5a5));
		drain();
		// box clipped at the far corner, width changed mid-scan
		set_screen(13'd8191, 13'd4096);
		send_word(make_load(4093, 4093, 4100, 4093, 4093, 4100, 24'h5a5a5a));
		send_steps(4);
		drain();
		set_screen(13'd5, 13'd4096);
		send_steps(5);
		drain();

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase % 6)
				0: begin wv = 13'd4096; hv = 13'd4096; end
				1: begin wv = 13'd1; hv = 13'd1; end
				2: begin wv = 13'd8191; hv = 13'd8191; end
				3: begin wv = 13'd0; hv = dim_t'($urandom_range(1, 8191)); end
				4: begin
					wv = dim_t'($urandom_range(1, 40));
					hv = dim_t'($urandom_range(1, 40));
				end
				default: begin
					wv = dim_t'($urandom_range(1, 8191));
					hv = (phase == 5) ? 13'd0 : dim_t'($urandom_range(1, 8191));
				end
			endcase
			set_screen(wv, hv);
			tx_gaps = (phase % 4 != 2) && (phase < NUM_PHASES - 1);
			rx_gaps = tx_gaps;
			if (phase == 4) hold_len = 80;
			count = 0;
			while (count < PHASE_ITEMS) begin
				k = $urandom_range(0, 99);
				if (k < 85) begin
					send_word(small_load(sb.clamp_dim(sb.width_reg),
					                     sb.clamp_dim(sb.height_reg)));
					n = sb.steps_left();
					// mostly full scans; the rest stop early and get abandoned
					if (k >= 70 && n > 0) n = $urandom_range(0, n - 1);
					send_steps(n);
					count += n + 1;
					if (k < 20) send_steps($urandom_range(1, 2));
				end else if (k < 95) begin
					send_word(random_word(ACT_LOAD));
					n = $urandom_range(0, 3);
					send_steps(n);
					count += n + 1;
				end else begin
					send_steps($urandom_range(1, 2));
					count++;
				end
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_triangle_edge_raster_top passed");
		else
			$display("tb_triangle_edge_raster_top failed");
		$finish;
	end

endmodule
